FILE: src/lpcc_pkg.sv
// ----------------------------------------------------------------------------
// lpcc_pkg
// Shared constants and codes for the page/column LCD controller.
// ----------------------------------------------------------------------------
`default_nettype none

package lpcc_pkg;

   // default screen geometry
   localparam int SCREEN_COLUMNS_DEFAULT = 128;
   localparam int SCREEN_PAGES_DEFAULT   = 8;

   // page command base after reset
   localparam logic [7:0] PAGE_BASE_RESET = 8'd176;

   // command bytes
   localparam logic [7:0] CMD_START      = 8'h40;
   localparam logic [7:0] CMD_DISPLAY_ON = 8'hAF;

   // low nibble mask for the column low byte
   localparam logic [7:0] NIBBLE_MASK = 8'h0F;

   // bus item kinds
   typedef enum logic [1:0] {
      MODE_COMMAND = 2'd0,
      MODE_DATA    = 2'd1,
      MODE_READ    = 2'd2
   } mode_type;

   // address sequence position
   typedef enum logic [1:0] {
      PHASE_NONE     = 2'd0,
      PHASE_PAGE     = 2'd1,
      PHASE_COL_HIGH = 2'd2,
      PHASE_COL_LOW  = 2'd3
   } phase_type;

endpackage

`default_nettype wire

FILE: src/lcd_page_column_controller_unit.sv
// A request beat is registered in stage one (with the frame-store read register), then in
// the result register; stage one holds while a result waits on rsp_tready. Throughput: one
// request beat per cycle unless the clearing sweep or a stalled result channel drops
// req_tready; each item does at most one frame-store access (a write or a registered read)
// in the cycle it is accepted. Reset: address registers, phase and flags clear; the frame
// store is swept to zero with req_tready low; csr writes are taken throughout.
// ----------------------------------------------------------------------------
// lcd_page_column_controller_unit
// Page-addressed monochrome LCD controller: command decode, address sequence,
// frame-store writes and read-back, with a two-stage result path.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_page_column_controller_unit #(
   parameter int SCREEN_COLUMNS = lpcc_pkg::SCREEN_COLUMNS_DEFAULT,
   parameter int SCREEN_PAGES   = lpcc_pkg::SCREEN_PAGES_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,  // byte_value[7:0], read_column[14:8], read_page[17:15]
   input  wire logic [1:0]  req_tuser,  // mode[1:0]
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,  // pixels_written[0], write_dropped[1], column_now[9:2],
                                        // page_now[17:10], read_data[25:18],
                                        // address_phase[27:26], sequence_active[28]
   // page command base register
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_data
);

   localparam int DEPTH  = SCREEN_COLUMNS * SCREEN_PAGES;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int IDX_W  = ADDR_W + 1;

   // request fields
   lpcc_pkg::mode_type mode;
   logic [7:0]         byte_value;
   logic [6:0]         read_column;
   logic [2:0]         read_page;

   assign mode        = lpcc_pkg::mode_type'(req_tuser);
   assign byte_value  = req_tdata[7:0];
   assign read_column = req_tdata[14:8];
   assign read_page   = req_tdata[17:15];

   // controller state
   logic [7:0]          page_base_ff;
   logic [7:0]          page_ff;
   logic [7:0]          page_in;
   logic [7:0]          column_ff;
   logic [7:0]          column_in;
   lpcc_pkg::phase_type phase_ff;
   lpcc_pkg::phase_type phase_in;
   logic                active_ff;
   logic                active_in;

   // handshake and pipeline control
   logic clear_busy;
   logic req_accept;
   logic s1_advance;
   logic s1_valid_ff;
   logic rsp_valid_ff;

   // per-item decode
   logic [7:0]        page_number;
   logic              write_on_screen;
   logic              read_on_screen;
   logic              wr_en;
   logic              rd_en;
   logic              written;
   logic              dropped;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic [IDX_W-1:0]  wr_index;
   logic [IDX_W-1:0]  rd_index;
   logic [7:0]        mem_rd_data;

   // stage one payload
   logic       s1_written_ff;
   logic       s1_dropped_ff;
   logic       s1_read_ok_ff;
   logic [7:0] s1_column_ff;
   logic [7:0] s1_page_ff;
   logic [1:0] s1_phase_ff;
   logic       s1_active_ff;

   // result register
   logic [31:0] rsp_data_ff;
   logic [7:0]  read_data;

   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !clear_busy && (!s1_valid_ff || s1_advance);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // page base register
   always_ff @(posedge clock) begin
      if (reset) begin
         page_base_ff <= lpcc_pkg::PAGE_BASE_RESET;
      end else if (csr_valid) begin
         page_base_ff <= csr_data;
      end
   end

   // write and read addressing
   assign page_number     = page_ff - page_base_ff;
   assign write_on_screen = (page_number < 8'(SCREEN_PAGES))
                            && ({1'b0, column_ff} < 9'(SCREEN_COLUMNS));
   assign read_on_screen  = ({2'b00, read_page} < 5'(SCREEN_PAGES))
                            && ({2'b00, read_column} < 9'(SCREEN_COLUMNS));
   assign wr_index = IDX_W'(page_number) * IDX_W'(SCREEN_COLUMNS) + IDX_W'(column_ff);
   assign rd_index = IDX_W'(read_page) * IDX_W'(SCREEN_COLUMNS) + IDX_W'(read_column);
   assign wr_addr  = wr_index[ADDR_W-1:0];
   assign rd_addr  = rd_index[ADDR_W-1:0];

   // command decode and address sequence
   always_comb begin
      page_in   = page_ff;
      column_in = column_ff;
      phase_in  = phase_ff;
      active_in = active_ff;
      written   = 1'b0;
      dropped   = 1'b0;
      case (mode)
         lpcc_pkg::MODE_COMMAND: begin
            if (byte_value == lpcc_pkg::CMD_START) begin
               page_in   = 8'h00;
               column_in = 8'h00;
               active_in = 1'b1;
               phase_in  = lpcc_pkg::PHASE_PAGE;
            end else if (byte_value == lpcc_pkg::CMD_DISPLAY_ON) begin
               page_in   = 8'h00;
               column_in = 8'h00;
               active_in = 1'b0;
               phase_in  = lpcc_pkg::PHASE_NONE;
            end else if (active_ff) begin
               case (phase_ff)
                  lpcc_pkg::PHASE_PAGE: begin
                     page_in  = byte_value;
                     phase_in = lpcc_pkg::PHASE_COL_HIGH;
                  end
                  lpcc_pkg::PHASE_COL_HIGH: begin
                     column_in = byte_value;
                     phase_in  = lpcc_pkg::PHASE_COL_LOW;
                  end
                  lpcc_pkg::PHASE_COL_LOW: begin
                     column_in = {column_ff[3:0], 4'h0} | (byte_value & lpcc_pkg::NIBBLE_MASK);
                     phase_in  = lpcc_pkg::PHASE_PAGE;
                  end
                  default: begin
                     phase_in = phase_ff;
                  end
               endcase
            end
         end
         lpcc_pkg::MODE_DATA: begin
            written   = write_on_screen;
            dropped   = !write_on_screen;
            column_in = column_ff + 8'd1;
         end
         default: begin
            written = 1'b0;
         end
      endcase
   end

   assign wr_en = req_accept && (mode == lpcc_pkg::MODE_DATA) && write_on_screen;
   assign rd_en = req_accept && (mode == lpcc_pkg::MODE_READ);

   // controller registers
   always_ff @(posedge clock) begin
      if (reset) begin
         page_ff   <= 8'h00;
         column_ff <= 8'h00;
         phase_ff  <= lpcc_pkg::PHASE_NONE;
         active_ff <= 1'b0;
      end else if (req_accept) begin
         page_ff   <= page_in;
         column_ff <= column_in;
         phase_ff  <= phase_in;
         active_ff <= active_in;
      end
   end

   lpcc_frame_store #(
      .SCREEN_COLUMNS (SCREEN_COLUMNS),
      .SCREEN_PAGES   (SCREEN_PAGES)
   ) u_frame_store (
      .clock      (clock),
      .reset      (reset),
      .clear_busy (clear_busy),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (byte_value),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (mem_rd_data)
   );

   // stage one valid
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   // stage one payload, the read byte waits in the memory's read register
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_written_ff <= written;
         s1_dropped_ff <= dropped;
         s1_read_ok_ff <= (mode == lpcc_pkg::MODE_READ) && read_on_screen;
         s1_column_ff  <= column_in;
         s1_page_ff    <= page_in;
         s1_phase_ff   <= phase_in;
         s1_active_ff  <= active_in;
      end
   end

   assign read_data = s1_read_ok_ff ? mem_rd_data : 8'h00;

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_data_ff <= {3'b000, s1_active_ff, s1_phase_ff, read_data, s1_page_ff,
                         s1_column_ff, s1_dropped_ff, s1_written_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

FILE: src/lpcc_frame_store.sv
// ----------------------------------------------------------------------------
// lpcc_frame_store
// Frame memory, one byte per page and column, with a clearing sweep after
// reset and a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lpcc_frame_store #(
   parameter int SCREEN_COLUMNS = lpcc_pkg::SCREEN_COLUMNS_DEFAULT,
   parameter int SCREEN_PAGES   = lpcc_pkg::SCREEN_PAGES_DEFAULT,
   localparam int DEPTH  = SCREEN_COLUMNS * SCREEN_PAGES,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   output logic                   clear_busy,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [7:0]        wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]             rd_data
);

   logic [7:0]        mem [DEPTH];
   logic              clear_busy_ff;
   logic              clear_busy_in;
   logic [ADDR_W-1:0] clear_addr_ff;
   logic [ADDR_W-1:0] clear_addr_in;
   logic [7:0]        rd_data_ff;

   // clearing sweep, one entry a cycle
   always_comb begin
      clear_busy_in = clear_busy_ff;
      clear_addr_in = clear_addr_ff;
      if (clear_busy_ff) begin
         clear_addr_in = clear_addr_ff + ADDR_W'(1);
         if (clear_addr_ff == ADDR_W'(DEPTH - 1)) begin
            clear_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff <= 1'b1;
         clear_addr_ff <= '0;
      end else begin
         clear_busy_ff <= clear_busy_in;
         clear_addr_ff <= clear_addr_in;
      end
   end

   // write port, sweep has priority
   always_ff @(posedge clock) begin
      if (clear_busy_ff) begin
         mem[clear_addr_ff] <= 8'h00;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read, holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign clear_busy = clear_busy_ff;
   assign rd_data    = rd_data_ff;

endmodule

`default_nettype wire

FILE: tb/lcd_page_column_controller_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lcd_page_column_controller_unit_tb
// Drives command, data, read-back and no-op beats into the LCD controller and
// compares every result beat against a cycle-free model of the frame store
// and the page/column address sequence, under several page command bases.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_page_column_controller_unit_tb;

   localparam int SCREEN_COLS  = lpcc_pkg::SCREEN_COLUMNS_DEFAULT;
   localparam int SCREEN_PGS   = lpcc_pkg::SCREEN_PAGES_DEFAULT;
   localparam int STORE_BYTES  = SCREEN_COLS * SCREEN_PGS;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 8;

   // the fourth bus kind does nothing but report the registers
   localparam logic [1:0] MODE_NOP = 2'd3;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] byte_value;
      logic [6:0] read_column;
      logic [2:0] read_page;
   } bus_item_type;

   typedef struct packed {
      logic       pixels_written;
      logic       write_dropped;
      logic [7:0] column_now;
      logic [7:0] page_now;
      logic [7:0] read_data;
      logic [1:0] address_phase;
      logic       sequence_active;
   } lcd_status_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata   = '0;
   logic [1:0]  req_tuser   = '0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_valid   = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_data    = '0;

   lcd_page_column_controller_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // byte_value[7:0], read_column[14:8], read_page[17:15]
      .req_tuser  (req_tuser),   // mode[1:0]
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // pixels_written[0], write_dropped[1], column_now[9:2],
                                 // page_now[17:10], read_data[25:18],
                                 // address_phase[27:26], sequence_active[28]
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // model state of the controller
   logic [7:0]          pixel_mem [STORE_BYTES];
   logic [7:0]          page_reg;
   logic [7:0]          column_reg;
   lpcc_pkg::phase_type addr_phase;
   logic                seq_active;
   logic [7:0]          page_base;

   bus_item_type   pending_items [$];
   lcd_status_type expected_status [$];
   bus_item_type   held_item;

   int mismatch_count = 0;
   int cycle_count    = 0;
   int items_made     = 0;
   bit idle_on        = 1'b1;
   int req_gap        = 0;
   int req_calm       = 0;
   int rsp_stall      = 0;
   int rsp_calm       = 0;

   // clock
   initial begin
      forever #4 clock = ~clock;
   end

   // command byte handling: start, display on, then the address loop
   function automatic void run_lcd_command(input logic [7:0] cmd);
      if (cmd == lpcc_pkg::CMD_START) begin
         page_reg   = '0;
         column_reg = '0;
         seq_active = 1'b1;
         addr_phase = lpcc_pkg::PHASE_PAGE;
      end else if (cmd == lpcc_pkg::CMD_DISPLAY_ON) begin
         page_reg   = '0;
         column_reg = '0;
         seq_active = 1'b0;
         addr_phase = lpcc_pkg::PHASE_NONE;
      end else if (seq_active) begin
         case (addr_phase)
            lpcc_pkg::PHASE_PAGE: begin
               page_reg   = cmd;
               addr_phase = lpcc_pkg::PHASE_COL_HIGH;
            end
            lpcc_pkg::PHASE_COL_HIGH: begin
               column_reg = cmd;
               addr_phase = lpcc_pkg::PHASE_COL_LOW;
            end
            lpcc_pkg::PHASE_COL_LOW: begin
               column_reg = (column_reg << 4) | (cmd & lpcc_pkg::NIBBLE_MASK);
               addr_phase = lpcc_pkg::PHASE_PAGE;
            end
            default: ;
         endcase
      end
   endfunction

   // advance the model by one accepted beat and return its status beat
   function automatic lcd_status_type apply_bus_item(input bus_item_type it);
      lcd_status_type st;
      logic [7:0]     page_num;
      st = '0;
      case (it.mode)
         lpcc_pkg::MODE_COMMAND: run_lcd_command(it.byte_value);
         lpcc_pkg::MODE_DATA: begin
            page_num = page_reg - page_base;
            if (page_num < SCREEN_PGS && column_reg < SCREEN_COLS) begin
               pixel_mem[int'(page_num) * SCREEN_COLS + int'(column_reg)] = it.byte_value;
               st.pixels_written = 1'b1;
            end else begin
               st.write_dropped = 1'b1;
            end
            column_reg = column_reg + 8'd1;
         end
         lpcc_pkg::MODE_READ: begin
            if (it.read_page < SCREEN_PGS && it.read_column < SCREEN_COLS)
               st.read_data = pixel_mem[int'(it.read_page) * SCREEN_COLS
                                        + int'(it.read_column)];
         end
         default: ;
      endcase
      st.column_now      = column_reg;
      st.page_now        = page_reg;
      st.address_phase   = addr_phase;
      st.sequence_active = seq_active;
      return st;
   endfunction

   // request driver
   always @(posedge clock) begin : req_driver
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            expected_status.push_back(apply_bus_item(held_item));
         if (req_calm > 0)
            req_calm--;
         else if ($urandom_range(0, 40) == 0)
            req_calm = $urandom_range(20, 80);
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_items.size() != 0) begin
               held_item = pending_items.pop_front();
               req_tdata  <= {6'd0, held_item.read_page, held_item.read_column,
                              held_item.byte_value};
               req_tuser  <= held_item.mode;
               req_tvalid <= 1'b1;
               if (idle_on && req_calm == 0 && $urandom_range(0, 4) == 0)
                  req_gap = $urandom_range(1, 10);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // result monitor and back-pressure
   always @(posedge clock) begin : rsp_monitor
      lcd_status_type want;
      if (reset) begin
         rsp_tready <= 1'b1;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_status.size() == 0) begin
               $display("%0t ns: result beat mismatch, expected none, got 0x%0h",
                        $time, rsp_tdata);
               mismatch_count++;
            end else begin
               want = expected_status.pop_front();
               check_field("pixels_written", want.pixels_written, rsp_tdata[0]);
               check_field("write_dropped", want.write_dropped, rsp_tdata[1]);
               check_field("column_now", want.column_now, rsp_tdata[9:2]);
               check_field("page_now", want.page_now, rsp_tdata[17:10]);
               check_field("read_data", want.read_data, rsp_tdata[25:18]);
               check_field("address_phase", want.address_phase, rsp_tdata[27:26]);
               check_field("sequence_active", want.sequence_active, rsp_tdata[28]);
            end
         end
         if (rsp_calm > 0)
            rsp_calm--;
         else if ($urandom_range(0, 40) == 0)
            rsp_calm = $urandom_range(20, 80);
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (idle_on && rsp_calm == 0 && $urandom_range(0, 4) == 0)
               rsp_stall = $urandom_range(1, 10);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin : run_watchdog
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic push_item(input logic [1:0] mode, input logic [7:0] value,
                            input logic [6:0] col, input logic [2:0] page);
      bus_item_type it;
      it.mode        = mode;
      it.byte_value  = value;
      it.read_column = col;
      it.read_page   = page;
      pending_items.push_back(it);
      if (mode != MODE_NOP)
         items_made++;
   endtask

   // command beat with random don't-care read fields
   task automatic push_command(input logic [7:0] value);
      push_item(lpcc_pkg::MODE_COMMAND, value, 7'($urandom_range(0, 127)),
                3'($urandom_range(0, 7)));
   endtask

   task automatic push_data(input logic [7:0] value);
      push_item(lpcc_pkg::MODE_DATA, value, 7'($urandom_range(0, 127)),
                3'($urandom_range(0, 7)));
   endtask

   task automatic push_read(input logic [6:0] col, input logic [2:0] page);
      push_item(lpcc_pkg::MODE_READ, 8'($urandom_range(0, 255)), col, page);
   endtask

   // address bytes must not collide with the two command codes
   function automatic logic [7:0] plain_byte(input logic [7:0] value);
      if (value == lpcc_pkg::CMD_START || value == lpcc_pkg::CMD_DISPLAY_ON)
         return value ^ 8'h01;
      return value;
   endfunction

   // csr write, only while nothing is in flight
   task automatic write_page_base(input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      page_base = value;
   endtask

   task automatic wait_until_drained();
      while (pending_items.size() != 0 || req_tvalid || expected_status.size() != 0)
         @(posedge clock);
   endtask

   // directed beats, written for the reset page base
   task automatic add_directed_items();
      push_command(8'h12);                 // other command while stopped
      push_data(8'hFF);                    // data while stopped, page off screen
      push_read(7'd127, 3'd7);             // cleared store
      push_item(MODE_NOP, 8'hFF, 7'd127, 3'd7);
      push_command(lpcc_pkg::CMD_START);
      push_command(8'hB0);
      push_command(8'h00);
      push_command(8'h00);
      push_data(8'hA5);
      push_data(8'h5A);
      push_read(7'd0, 3'd0);
      push_command(8'hB7);                 // sequence loops back to page
      push_command(8'h07);
      push_command(8'hFF);
      push_data(8'hFF);                    // last column of last page
      push_data(8'h01);                    // column 128, dropped
      push_read(7'd127, 3'd7);
      push_command(8'hBF);                 // page 15, off screen
      push_command(8'h0F);
      push_command(8'hFF);                 // column 0xff via shift and nibble
      push_data(8'h3C);                    // dropped, column wraps to zero
      push_command(lpcc_pkg::CMD_START);   // start while expecting a page
      push_command(8'hB1);
      push_command(lpcc_pkg::CMD_DISPLAY_ON); // stop mid sequence
      push_command(8'hB2);                 // ignored
      push_data(8'h81);
   endtask

   // mostly well-formed address sequences with data and reads, some noise
   task automatic add_random_items(input int count);
      int         stop_at;
      int         kind;
      logic [7:0] page_byte;
      logic [7:0] hi;
      logic [7:0] lo;
      logic [7:0] page_num;
      logic [7:0] col;
      stop_at = items_made + count;
      while (items_made < stop_at) begin
         kind = $urandom_range(0, 9);
         if (kind < 7) begin
            push_command(lpcc_pkg::CMD_START);
            repeat ($urandom_range(1, 3)) begin
               if ($urandom_range(0, 7) == 0)
                  page_byte = plain_byte(8'($urandom_range(0, 255)));
               else
                  page_byte = plain_byte(page_base + 8'($urandom_range(0, SCREEN_PGS - 1)));
               hi = 8'($urandom_range(0, 255));
               if ($urandom_range(0, 5) != 0)
                  hi[3] = 1'b0;
               hi = plain_byte(hi);
               lo = plain_byte(8'($urandom_range(0, 255)));
               push_command(page_byte);
               push_command(hi);
               push_command(lo);
               page_num = page_byte - page_base;
               col      = {hi[3:0], lo[3:0]};
               repeat ($urandom_range(1, 12)) begin
                  if ($urandom_range(0, 4) == 0) begin
                     if ($urandom_range(0, 1) == 0)
                        push_read(7'(col - 8'd1), page_num[2:0]);
                     else
                        push_read(7'($urandom_range(0, 127)), 3'($urandom_range(0, 7)));
                  end else begin
                     push_data(8'($urandom_range(0, 255)));
                     col = col + 8'd1;
                  end
               end
            end
            if ($urandom_range(0, 3) == 0) begin
               push_command(lpcc_pkg::CMD_DISPLAY_ON);
               push_data(8'($urandom_range(0, 255)));
            end
         end else if (kind == 7) begin
            // broken sequence cut short by a command
            push_command(lpcc_pkg::CMD_START);
            repeat ($urandom_range(0, 2))
               push_command(plain_byte(8'($urandom_range(0, 255))));
            push_command($urandom_range(0, 1) ? lpcc_pkg::CMD_START
                                              : lpcc_pkg::CMD_DISPLAY_ON);
         end else begin
            repeat ($urandom_range(1, 5))
               push_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                         7'($urandom_range(0, 127)), 3'($urandom_range(0, 7)));
         end
      end
   endtask

   // main sequence
   initial begin
      for (int i = 0; i < STORE_BYTES; i++)
         pixel_mem[i] = '0;
      page_reg   = '0;
      column_reg = '0;
      addr_phase = lpcc_pkg::PHASE_NONE;
      seq_active = 1'b0;
      page_base  = lpcc_pkg::PAGE_BASE_RESET;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      write_page_base(lpcc_pkg::PAGE_BASE_RESET);
      add_directed_items();
      add_random_items(300);
      wait_until_drained();

      write_page_base(8'h00);
      add_random_items(300);
      wait_until_drained();

      write_page_base(8'hFF);
      add_random_items(300);
      wait_until_drained();

      // closing phase runs at full rate
      idle_on = 1'b0;
      write_page_base(8'($urandom_range(1, 254)));
      add_random_items(300);
      wait_until_drained();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

`default_nettype wire
